FILE: hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timestamp table package
// Shared codes, field widths, the control and status bundles between the
// controller and the datapath, and the month length table.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  // Default number of table entries
  localparam int unsigned TableDepth = 32;

  // Field widths of one word
  localparam int unsigned KindW   = 2;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 6;
  localparam int unsigned KeyW    = YearW + MonthW + DayW + HourW + MinuteW;

  // Operation codes
  localparam logic [KindW-1:0] KindInsert = 2'd0;
  localparam logic [KindW-1:0] KindRemove = 2'd1;
  localparam logic [KindW-1:0] KindLookup = 2'd2;
  localparam logic [KindW-1:0] KindList   = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] StOk   = 2'd0;
  localparam logic [StatusW-1:0] StMiss = 2'd1;
  localparam logic [StatusW-1:0] StFull = 2'd2;
  localparam logic [StatusW-1:0] StBad  = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic               capture;
    logic               rd_en;
    logic               wr_en;
    logic               wr_key;
    logic               cnt_inc;
    logic               cnt_dec;
    logic               out_load;
    logic               out_has_key;
    logic               out_last;
    logic [StatusW-1:0] out_status;
  } sts_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             date_ok;
    logic             ge;
    logic             eq;
    logic             out_free;
  } sts_stat_t;

  // Days in a month; zero for codes that name no month
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                  input logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sts_datapath.sv
// ----------------------------------------------------------------------------
// Sorted timestamp table datapath
// Entry memory with registered read, key and count registers, date check,
// key comparators and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_datapath #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::TableDepth,
  parameter int unsigned AddrW       = $clog2(TABLE_DEPTH),
  parameter int unsigned CntW        = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input word fields
  input  wire logic [sts_pkg::KindW-1:0]    kind_i,
  input  wire logic [sts_pkg::YearW-1:0]    year_i,
  input  wire logic [sts_pkg::MonthW-1:0]   month_i,
  input  wire logic [sts_pkg::DayW-1:0]     day_i,
  input  wire logic [sts_pkg::HourW-1:0]    hour_i,
  input  wire logic [sts_pkg::MinuteW-1:0]  minute_i,
  // controller side
  input  wire sts_pkg::sts_cmd_t            cmd_i,
  input  wire logic [AddrW-1:0]             rd_addr_i,
  input  wire logic [AddrW-1:0]             wr_addr_i,
  output sts_pkg::sts_stat_t                stat_o,
  output logic [CntW-1:0]                   count_o,
  // output word
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [sts_pkg::StatusW-1:0]       status_o,
  output logic [sts_pkg::CountW-1:0]        entry_count_o,
  output logic [sts_pkg::YearW-1:0]         out_year_o,
  output logic [sts_pkg::MonthW-1:0]        out_month_o,
  output logic [sts_pkg::DayW-1:0]          out_day_o,
  output logic [sts_pkg::HourW-1:0]         out_hour_o,
  output logic [sts_pkg::MinuteW-1:0]       out_minute_o,
  output logic                              last_o
);

  import sts_pkg::*;

  // Divisibility by 25 through the modular inverse of 25 mod 2^12
  localparam logic [YearW-1:0] Inv25    = 12'd3113;
  localparam logic [YearW-1:0] Div25Max = 12'd163;
  localparam logic [YearW-1:0] YearMin  = 12'd1900;

  logic [KeyW-1:0]   mem [TABLE_DEPTH];
  logic [KeyW-1:0]   rdata_q;
  logic [KeyW-1:0]   key_q;
  logic [KindW-1:0]  kind_q;
  logic [CntW-1:0]   count_q;
  logic              out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [CountW-1:0] entry_count_q;
  logic [KeyW-1:0]   out_key_q;
  logic              last_q;

  // key fields
  logic [YearW-1:0]   k_year;
  logic [MonthW-1:0]  k_month;
  logic [DayW-1:0]    k_day;
  logic [HourW-1:0]   k_hour;
  logic [MinuteW-1:0] k_minute;
  logic [YearW-1:0]   mod_prod;
  logic               div25;
  logic               leap;
  logic [DayW-1:0]    mlen;
  logic               out_free;

  assign {k_year, k_month, k_day, k_hour, k_minute} = key_q;

  // Check the calendar date of the held key
  assign mod_prod = k_year * Inv25;
  assign div25    = (mod_prod <= Div25Max);
  assign leap     = ((k_year[1:0] == 2'd0) && !div25) || ((k_year[3:0] == 4'd0) && div25);
  assign mlen     = month_days(k_month, leap);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.kind     = kind_q;
    stat_o.date_ok  = (k_year >= YearMin) && (k_hour <= 5'd23) && (k_minute <= 6'd59)
                   && (k_day != 5'd0) && (k_day <= mlen);
    stat_o.ge       = (rdata_q >= key_q);
    stat_o.eq       = (rdata_q == key_q);
    stat_o.out_free = out_free;
  end

  assign count_o = count_q;

  // Entry memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= cmd_i.wr_key ? key_q : rdata_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // Hold the accepted word and load the output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q  <= {year_i, month_i, day_i, hour_i, minute_i};
      kind_q <= kind_i;
    end
    if (cmd_i.out_load) begin
      status_q      <= cmd_i.out_status;
      entry_count_q <= CountW'(count_q);
      out_key_q     <= cmd_i.out_has_key ? rdata_q : '0;
      last_q        <= cmd_i.out_last;
    end
  end

  // Track the entry count and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CntW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;
  assign {out_year_o, out_month_o, out_day_o, out_hour_o, out_minute_o} = out_key_q;
  assign last_o        = last_q;

  // A write lands inside the filled part of the table or just past it
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (CntW'(wr_addr_i) <= count_q))
    else $error("write beyond the filled entries");

  // The count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

endmodule

`default_nettype wire

FILE: hdl/sts_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted timestamp table controller
// Sequences check, walk, shift and list steps over the entry memory, one
// read or one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_ctrl #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::TableDepth,
  parameter int unsigned AddrW       = $clog2(TABLE_DEPTH),
  parameter int unsigned CntW        = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sts_pkg::sts_stat_t  stat_i,
  input  wire logic [CntW-1:0]     count_i,
  output sts_pkg::sts_cmd_t        cmd_o,
  output logic [AddrW-1:0]         rd_addr_o,
  output logic [AddrW-1:0]         wr_addr_o
);

  import sts_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SCheck = 4'd1;
  localparam logic [3:0] SEmit  = 4'd2;
  localparam logic [3:0] SIRd   = 4'd3;
  localparam logic [3:0] SIEv   = 4'd4;
  localparam logic [3:0] SIPut  = 4'd5;
  localparam logic [3:0] SSRd   = 4'd6;
  localparam logic [3:0] SSEv   = 4'd7;
  localparam logic [3:0] SRRd   = 4'd8;
  localparam logic [3:0] SREv   = 4'd9;
  localparam logic [3:0] SLRd   = 4'd10;
  localparam logic [3:0] SLEv   = 4'd11;

  logic [3:0]         state_q, state_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [StatusW-1:0] st_q, st_d;
  logic [CntW-1:0]    idx_m1, idx_p1, cnt_m1;
  logic               full;

  assign idx_m1 = idx_q - CntW'(1);
  assign idx_p1 = idx_q + CntW'(1);
  assign cnt_m1 = count_i - CntW'(1);
  assign full   = (count_i == CntW'(TABLE_DEPTH));

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    st_d       = st_q;
    cmd_o      = '0;
    rd_addr_o  = idx_q[AddrW-1:0];
    wr_addr_o  = idx_q[AddrW-1:0];
    in_ready_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = SCheck;
        end
      end
      SCheck: begin
        if (stat_i.kind == KindList) begin
          if (count_i == '0) begin
            st_d    = StMiss;
            state_d = SEmit;
          end else begin
            idx_d   = '0;
            state_d = SLRd;
          end
        end else if (!stat_i.date_ok) begin
          st_d    = StBad;
          state_d = SEmit;
        end else if (stat_i.kind == KindInsert) begin
          if (full) begin
            st_d    = StFull;
            state_d = SEmit;
          end else if (count_i == '0) begin
            idx_d   = '0;
            state_d = SIPut;
          end else begin
            idx_d   = count_i;
            state_d = SIRd;
          end
        end else if (count_i == '0) begin
          st_d    = StMiss;
          state_d = SEmit;
        end else begin
          idx_d   = '0;
          state_d = SSRd;
        end
      end
      SEmit: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = st_q;
          cmd_o.out_last   = 1'b1;
          state_d          = SIdle;
        end
      end
      // insert: walk down from the top, moving later entries up one slot
      SIRd: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = idx_m1[AddrW-1:0];
        state_d     = SIEv;
      end
      SIEv: begin
        if (stat_i.ge) begin
          cmd_o.wr_en = 1'b1;
          idx_d       = idx_m1;
          state_d     = (idx_m1 == '0) ? SIPut : SIRd;
        end else begin
          state_d = SIPut;
        end
      end
      SIPut: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_key  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        st_d          = StOk;
        state_d       = SEmit;
      end
      // remove and lookup: search up from the bottom
      SSRd: begin
        cmd_o.rd_en = 1'b1;
        state_d     = SSEv;
      end
      SSEv: begin
        if (stat_i.eq) begin
          st_d = StOk;
          if (stat_i.kind == KindLookup) begin
            state_d = SEmit;
          end else if (idx_q == cnt_m1) begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = SEmit;
          end else begin
            state_d = SRRd;
          end
        end else if (idx_q == cnt_m1) begin
          st_d    = StMiss;
          state_d = SEmit;
        end else begin
          idx_d   = idx_p1;
          state_d = SSRd;
        end
      end
      // remove: close the gap, moving later entries down one slot
      SRRd: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = idx_p1[AddrW-1:0];
        state_d     = SREv;
      end
      SREv: begin
        cmd_o.wr_en = 1'b1;
        idx_d       = idx_p1;
        if (idx_p1 == cnt_m1) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = SEmit;
        end else begin
          state_d = SRRd;
        end
      end
      // list: one entry per output word
      SLRd: begin
        cmd_o.rd_en = 1'b1;
        state_d     = SLEv;
      end
      SLEv: begin
        if (stat_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_status  = StOk;
          cmd_o.out_has_key = 1'b1;
          cmd_o.out_last    = (idx_q == cnt_m1);
          if (idx_q == cnt_m1) begin
            state_d = SIdle;
          end else begin
            idx_d   = idx_p1;
            state_d = SLRd;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
      st_q    <= StOk;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      st_q    <= st_d;
    end
  end

  // An output word is loaded only into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("output word overwritten");

  // The table is never written while waiting for a new word
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> !cmd_o.wr_en)
    else $error("table written while idle");

  // An insert completes only below the table depth
  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cnt_inc |-> !full)
    else $error("insert into a full table");

endmodule

`default_nettype wire

FILE: hdl/sorted_timestamp_table_core.sv
// ----------------------------------------------------------------------------
// Sorted timestamp table
// Bounded table of timestamps kept in ascending order, with insert, remove,
// lookup and list operations over valid/ready channels.
// ----------------------------------------------------------------------------
// The block takes one word at a time and accepts the next only after the
// previous one has finished its table work; a finished output word may still
// wait in the output register. Each table step is a read of the entry memory
// followed by an evaluate cycle. An insert walks down from the top and moves
// later entries up one slot, a remove or lookup searches up from the bottom,
// a remove then closes the gap, and a list reads every entry in turn, waiting
// for a free output register for each. Invalid dates and inserts into a full
// table answer straight from the check step. No clearing pass is needed after
// reset.
`default_nettype none

module sorted_timestamp_table_core #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::TableDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input words
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [sts_pkg::KindW-1:0]    kind_i,
  input  wire logic [sts_pkg::YearW-1:0]    year_i,
  input  wire logic [sts_pkg::MonthW-1:0]   month_i,
  input  wire logic [sts_pkg::DayW-1:0]     day_i,
  input  wire logic [sts_pkg::HourW-1:0]    hour_i,
  input  wire logic [sts_pkg::MinuteW-1:0]  minute_i,
  // output words
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [sts_pkg::StatusW-1:0]       status_o,
  output logic [sts_pkg::CountW-1:0]        entry_count_o,
  output logic [sts_pkg::YearW-1:0]         out_year_o,
  output logic [sts_pkg::MonthW-1:0]        out_month_o,
  output logic [sts_pkg::DayW-1:0]          out_day_o,
  output logic [sts_pkg::HourW-1:0]         out_hour_o,
  output logic [sts_pkg::MinuteW-1:0]       out_minute_o,
  output logic                              last_o
);

  import sts_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);

  sts_cmd_t         cmd;
  sts_stat_t        stat;
  logic [CntW-1:0]  count;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;

  // Sequencer
  sts_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AddrW       (AddrW),
    .CntW        (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .count_i    (count),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr)
  );

  // Table storage and output register
  sts_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AddrW       (AddrW),
    .CntW        (CntW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_i         (day_i),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .wr_addr_i     (wr_addr),
    .stat_o        (stat),
    .count_o       (count),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .out_year_o    (out_year_o),
    .out_month_o   (out_month_o),
    .out_day_o     (out_day_o),
    .out_hour_o    (out_hour_o),
    .out_minute_o  (out_minute_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
